[hdl/mp2d_pkg.sv]
// Package for the 2-D max pooling block: types, constants and float compare.
`default_nettype none
package mp2d_pkg;
    localparam logic [31:0] NEG_FLT_MAX = 32'hFF7F_FFFF;

    typedef enum logic [2:0] {
        REG_IN_WIDTH      = 3'd0,
        REG_IN_HEIGHT     = 3'd1,
        REG_OUT_WIDTH     = 3'd2,
        REG_OUT_HEIGHT    = 3'd3,
        REG_WINDOW_WIDTH  = 3'd4,
        REG_WINDOW_HEIGHT = 3'd5,
        REG_STRIDE_WIDTH  = 3'd6,
        REG_STRIDE_HEIGHT = 3'd7
    } cfg_reg_t;

    // Window scan job handed from the front end to the scanner.
    typedef struct packed {
        logic [15:0] ry;
        logic [15:0] oy;
        logic [11:0] rx;
        logic [7:0]  ox;
    } scan_job_t;

    // IEEE single a > b, false when either is NaN; +0 and -0 compare equal.
    function automatic logic fp_gt(input logic [31:0] a, input logic [31:0] b);
        logic a_nan;
        logic b_nan;
        logic both_zero;
        logic res;
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
        if (a_nan || b_nan || both_zero) begin
            res = 1'b0;
        end else if (a[31] != b[31]) begin
            res = !a[31];
        end else if (!a[31]) begin
            res = a[30:0] > b[30:0];
        end else begin
            res = a[30:0] < b[30:0];
        end
        return res;
    endfunction
endpackage
`default_nettype wire

[hdl/mp2d_scan.sv]
// Window scanner: walks the line store one entry a cycle and keeps the maximum.
`default_nettype none
module mp2d_scan #(
    parameter int ROW_BITS = 3,
    parameter int COL_BITS = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire mp2d_pkg::scan_job_t           job,
    input  wire logic [3:0]                    win_w,
    input  wire logic [3:0]                    win_h,
    output logic                               busy,
    output logic                               rd_en,
    output logic [ROW_BITS+COL_BITS-1:0]       rd_addr,
    input  wire logic [31:0]                   rd_data,
    output logic                               done,
    output logic [31:0]                        best,
    input  wire logic                          done_ack
);
    import mp2d_pkg::*;

    localparam int DEPTH_ROWS = 1 << ROW_BITS;
    localparam int WIDTH_COLS = 1 << COL_BITS;

    logic              busy_reg, busy_next;
    logic              issue_reg, issue_next;   // address phase active
    logic              vld_reg, vld_next;       // data from last read arrives
    logic              done_reg, done_next;
    logic [3:0]        dy_reg, dy_next;
    logic [3:0]        dx_reg, dx_next;
    logic [31:0]       best_reg, best_next;
    scan_job_t         job_reg;
    logic [15:0]       y;
    logic [11:0]       x;

    assign y = job_reg.ry + 16'(dy_reg);
    assign x = job_reg.rx + 12'(dx_reg);
    assign rd_en = issue_reg;
    assign rd_addr = {y[ROW_BITS-1:0], x[COL_BITS-1:0]};
    assign busy = busy_reg;
    assign done = done_reg;
    assign best = best_reg;

    always_comb begin
        busy_next = busy_reg;
        issue_next = issue_reg;
        vld_next = issue_reg;
        done_next = done_reg && !done_ack;
        dy_next = dy_reg;
        dx_next = dx_reg;
        best_next = best_reg;
        if (vld_reg && fp_gt(rd_data, best_reg)) begin
            best_next = rd_data;
        end
        if (start) begin
            busy_next = 1'b1;
            issue_next = 1'b1;
            dy_next = '0;
            dx_next = '0;
            best_next = NEG_FLT_MAX;
        end else if (issue_reg) begin
            if (dx_reg + 4'd1 >= win_w) begin
                dx_next = '0;
                dy_next = dy_reg + 4'd1;
                if (dy_reg + 4'd1 >= win_h) begin
                    issue_next = 1'b0;
                end
            end else begin
                dx_next = dx_reg + 4'd1;
            end
        end else if (busy_reg && !vld_reg) begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            issue_reg <= 1'b0;
            vld_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            issue_reg <= issue_next;
            vld_reg <= vld_next;
            done_reg <= done_next;
        end
        dy_reg <= dy_next;
        dx_reg <= dx_next;
        best_reg <= best_next;
        if (start) begin
            job_reg <= job;
        end
    end

    logic unused_ok;
    assign unused_ok = ^{job_reg.oy, job_reg.ox, DEPTH_ROWS[0], WIDTH_COLS[0]};
endmodule
`default_nettype wire

[hdl/max_pool_2d_forward.sv]
// Top level of the 2-D max pooling block: handshakes, counters, line store.
//
// Channel  Dir  Ports                        Payload
// s_       in   s_tvalid s_tready s_tdata    pixel[31:0]
// m_       out  m_tvalid m_tready m_tdata    pooled_value, out_row, out_col
// cfg      in   cfg_we cfg_index cfg_wdata   register write, no read-back
//
// A pixel that closes no window does not lower s_tready. After a closing pixel
// the next pixel waits until the scanner has read the whole window through the
// single read port of the line store (one entry per cycle). A finished scan
// holds s_tready low until the output register is free. aresetn is synchronous
// and clears counters and handshake state; the line store is not cleared.
`default_nettype none
module max_pool_2d_forward #(
    parameter int MAX_IN_WIDTH = 256,
    parameter int MAX_WINDOW_H = 8,
    parameter int MAX_WINDOW_W = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] pixel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [31:0] pooled_value, [47:32] out_row, [55:48] out_col
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);
    import mp2d_pkg::*;

    localparam int ROW_BITS = (MAX_WINDOW_H <= 1) ? 1 : $clog2(MAX_WINDOW_H);
    localparam int COL_BITS = $clog2(MAX_IN_WIDTH);
    localparam int ADDR_BITS = ROW_BITS + COL_BITS;
    localparam int DEPTH = 1 << ADDR_BITS;

    logic [8:0]  in_width_reg;
    logic [15:0] in_height_reg;
    logic [8:0]  out_width_reg;
    logic [15:0] out_height_reg;
    logic [3:0]  window_width_reg, window_height_reg;
    logic [3:0]  stride_width_reg, stride_height_reg;

    logic [15:0] row_count_reg, row_count_next;
    logic [11:0] col_count_reg, col_count_next;
    // window origin phases: distance into current stride, and origin index
    logic [3:0]  ph_x_reg, ph_x_next, ph_y_reg, ph_y_next;
    logic [11:0] ox_reg, ox_next;
    logic [15:0] oy_reg, oy_next;

    logic [31:0] store [DEPTH];
    logic [31:0] rd_data_reg;

    logic [12:0] iw, ww13;
    logic [15:0] ih;
    logic [3:0]  ww, wh, sw, sh;
    always_comb begin
        iw = (in_width_reg == 9'd0) ? 13'd1 : 13'(in_width_reg);
        if (iw > 13'(MAX_IN_WIDTH)) iw = 13'(MAX_IN_WIDTH);
        ih = (in_height_reg == 16'd0) ? 16'd1 : in_height_reg;
        ww = (window_width_reg == 4'd0) ? 4'd1 : window_width_reg;
        if (int'(ww) > MAX_WINDOW_W) ww = 4'(MAX_WINDOW_W);
        wh = (window_height_reg == 4'd0) ? 4'd1 : window_height_reg;
        if (int'(wh) > MAX_WINDOW_H) wh = 4'(MAX_WINDOW_H);
        sw = (stride_width_reg == 4'd0) ? 4'd1 : stride_width_reg;
        sh = (stride_height_reg == 4'd0) ? 4'd1 : stride_height_reg;
        ww13 = 13'(ww);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_width_reg <= 9'd1;
            in_height_reg <= 16'd1;
            out_width_reg <= 9'd1;
            out_height_reg <= 16'd1;
            window_width_reg <= 4'd2;
            window_height_reg <= 4'd2;
            stride_width_reg <= 4'd2;
            stride_height_reg <= 4'd2;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_IN_WIDTH:      in_width_reg <= cfg_wdata[8:0];
                REG_IN_HEIGHT:     in_height_reg <= cfg_wdata;
                REG_OUT_WIDTH:     out_width_reg <= cfg_wdata[8:0];
                REG_OUT_HEIGHT:    out_height_reg <= cfg_wdata;
                REG_WINDOW_WIDTH:  window_width_reg <= cfg_wdata[3:0];
                REG_WINDOW_HEIGHT: window_height_reg <= cfg_wdata[3:0];
                REG_STRIDE_WIDTH:  stride_width_reg <= cfg_wdata[3:0];
                REG_STRIDE_HEIGHT: stride_height_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // scanner
    logic                 scan_start, scan_busy, scan_rd_en, scan_done, scan_ack;
    logic [ADDR_BITS-1:0] scan_addr;
    logic [31:0]          scan_best;
    scan_job_t            job;

    mp2d_scan #(.ROW_BITS(ROW_BITS), .COL_BITS(COL_BITS)) u_scan (
        .aclk(aclk), .aresetn(aresetn),
        .start(scan_start), .job(job), .win_w(ww), .win_h(wh),
        .busy(scan_busy), .rd_en(scan_rd_en), .rd_addr(scan_addr),
        .rd_data(rd_data_reg), .done(scan_done), .best(scan_best),
        .done_ack(scan_ack)
    );

    logic        m_valid_reg, m_valid_next;
    logic [55:0] m_data_reg;
    logic [15:0] pend_oy_reg;
    logic [7:0]  pend_ox_reg;

    // one scan in flight; the scan result needs the output register free
    assign s_tready = !scan_busy && !scan_done;
    logic accept;
    assign accept = s_tvalid && s_tready;

    logic in_col, y_ok, x_ok, fire;
    logic [15:0] r1;
    logic [12:0] c1;
    always_comb begin
        r1 = row_count_reg + 16'd1;
        c1 = 13'(col_count_reg) + 13'd1;
        in_col = 13'(col_count_reg) < iw;
        y_ok = (17'(row_count_reg) + 17'd1 >= 17'(wh)) && (ph_y_reg == 4'd0)
               && (oy_reg < out_height_reg) && (row_count_reg < ih);
        x_ok = (c1 >= ww13) && (ph_x_reg == 4'd0) && (ox_reg < 12'(out_width_reg));
        fire = accept && in_col && y_ok && x_ok;
        job.ry = r1 - 16'(wh);
        job.rx = 12'(c1 - ww13);
        job.oy = oy_reg;
        job.ox = ox_reg[7:0];
        scan_start = fire;
    end

    // position and window-phase counters
    always_comb begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        ph_x_next = ph_x_reg;
        ph_y_next = ph_y_reg;
        ox_next = ox_reg;
        oy_next = oy_reg;
        if (accept) begin
            if (c1 >= ww13) begin
                if (ph_x_reg + 4'd1 >= sw) begin
                    ph_x_next = '0;
                    ox_next = ox_reg + 12'd1;
                end else begin
                    ph_x_next = ph_x_reg + 4'd1;
                end
            end
            if (c1 >= iw) begin
                col_count_next = '0;
                ph_x_next = '0;
                ox_next = '0;
                if (r1 >= ih) begin
                    row_count_next = '0;
                    ph_y_next = '0;
                    oy_next = '0;
                end else begin
                    row_count_next = r1;
                    if (17'(r1) >= 17'(wh)) begin
                        if (17'(row_count_reg) + 17'd1 >= 17'(wh)) begin
                            if (ph_y_reg + 4'd1 >= sh) begin
                                ph_y_next = '0;
                                oy_next = oy_reg + 16'd1;
                            end else begin
                                ph_y_next = ph_y_reg + 4'd1;
                            end
                        end
                    end
                end
            end else begin
                col_count_next = 12'(c1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= '0;
            col_count_reg <= '0;
            ph_x_reg <= '0;
            ph_y_reg <= '0;
            ox_reg <= '0;
            oy_reg <= '0;
        end else begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            ph_x_reg <= ph_x_next;
            ph_y_reg <= ph_y_next;
            ox_reg <= ox_next;
            oy_reg <= oy_next;
        end
    end

    // line store: write on accept, scanner reads one entry a cycle.
    // the closing pixel is written on accept, before the scan reads start.
    always_ff @(posedge aclk) begin
        if (accept && in_col) begin
            store[{row_count_reg[ROW_BITS-1:0], col_count_reg[COL_BITS-1:0]}] <= s_tdata;
        end
        if (scan_rd_en) begin
            rd_data_reg <= store[scan_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            pend_oy_reg <= oy_reg;
            pend_ox_reg <= ox_reg[7:0];
        end
    end

    assign scan_ack = scan_done && (!m_valid_reg || m_tready);
    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        if (scan_ack) m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (scan_ack) begin
            m_data_reg <= {pend_ox_reg, pend_oy_reg, scan_best};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;

    // a new pixel is never taken while a scan is running
    a_no_accept_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_busy |-> !s_tready) else $error("pixel accepted during scan");
    // a finished scan is handed off only into a free output register
    a_handoff: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_ack |-> (!m_valid_reg || m_tready)) else $error("output overwritten");
    // a scan always ends with scan_done set
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(scan_busy) |-> scan_done) else $error("scan ended without result");
endmodule
`default_nettype wire

[tb/pool_checker.sv]
// Checker for the 2-D max pooling block: tracks registers, predicts windows, compares results.
`default_nettype none
module pool_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [55:0] m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    output int               fail_count,
    output int               pending,
    output int               result_count
);
    import mp2d_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] value;
        logic [15:0] row;
        logic [7:0]  col;
    } pool_result_t;

    logic [8:0]  in_w, out_w;
    logic [15:0] in_h, out_h;
    logic [3:0]  win_w, win_h, step_w, step_h;
    logic [31:0] line_mem [0:2047];
    int unsigned row_pos, col_pos;
    pool_result_t window_max_q[$];
    int errors = 0;
    int seen = 0;

    assign fail_count   = errors;
    assign pending      = window_max_q.size();
    assign result_count = seen;

    function automatic bit is_nan(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    // Monotonic key for non-NaN floats; both zeros map to one key.
    function automatic logic [31:0] order_key(input logic [31:0] x);
        if (x[30:0] == 31'd0) return 32'h8000_0000;
        return x[31] ? ~x : (x | 32'h8000_0000);
    endfunction

    function automatic bit beats(input logic [31:0] a, input logic [31:0] b);
        if (is_nan(a) || is_nan(b)) return 1'b0;
        return order_key(a) > order_key(b);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic predict_pixel(input logic [31:0] px);
        int unsigned iw, ih, ww, wh, sw, sh, r, c, ry, rx, oy, ox;
        logic [31:0] best, v;
        iw = (in_w == 0) ? 1 : ((in_w > 256) ? 256 : in_w);
        ih = (in_h == 0) ? 1 : in_h;
        ww = (win_w == 0) ? 1 : ((win_w > 8) ? 8 : win_w);
        wh = (win_h == 0) ? 1 : ((win_h > 8) ? 8 : win_h);
        sw = (step_w == 0) ? 1 : step_w;
        sh = (step_h == 0) ? 1 : step_h;
        r = row_pos;
        c = col_pos;
        if (c < iw) begin
            line_mem[((r % 8) * 256 + c) % 2048] = px;
            if (r + 1 >= wh && c + 1 >= ww && r < ih) begin
                ry = r + 1 - wh;
                rx = c + 1 - ww;
                if (ry % sh == 0 && rx % sw == 0) begin
                    oy = ry / sh;
                    ox = rx / sw;
                    if (oy < out_h && ox < out_w) begin
                        best = NEG_FLT_MAX;
                        for (int dy = 0; dy < wh; dy++) begin
                            for (int dx = 0; dx < ww; dx++) begin
                                v = line_mem[(((ry + dy) % 8) * 256 + rx + dx) % 2048];
                                if (beats(v, best)) best = v;
                            end
                        end
                        window_max_q.push_back('{best, oy[15:0], ox[7:0]});
                    end
                end
            end
        end
        if (c + 1 >= iw) begin
            col_pos = 0;
            row_pos = (r + 1 >= ih) ? 0 : ((r + 1) & 16'hFFFF);
        end else begin
            col_pos = c + 1;
        end
    endtask

    always @(posedge aclk) begin
        pool_result_t want;
        if (!aresetn) begin
            in_w = 9'd1; in_h = 16'd1; out_w = 9'd1; out_h = 16'd1;
            win_w = 4'd2; win_h = 4'd2; step_w = 4'd2; step_h = 4'd2;
            row_pos = 0;
            col_pos = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen++;
                if (window_max_q.size() == 0) begin
                    $display("%0t unexpected result transaction %h", $realtime, m_tdata);
                    errors++;
                end else begin
                    want = window_max_q.pop_front();
                    if (m_tdata[31:0] !== want.value)
                        report_mismatch("pooled_value", m_tdata[31:0], want.value);
                    if (m_tdata[47:32] !== want.row)
                        report_mismatch("out_row", 32'(m_tdata[47:32]), 32'(want.row));
                    if (m_tdata[55:48] !== want.col)
                        report_mismatch("out_col", 32'(m_tdata[55:48]), 32'(want.col));
                end
            end
            if (s_tvalid && s_tready) predict_pixel(s_tdata);
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_IN_WIDTH:      in_w   = cfg_wdata[8:0];
                    REG_IN_HEIGHT:     in_h   = cfg_wdata;
                    REG_OUT_WIDTH:     out_w  = cfg_wdata[8:0];
                    REG_OUT_HEIGHT:    out_h  = cfg_wdata;
                    REG_WINDOW_WIDTH:  win_w  = cfg_wdata[3:0];
                    REG_WINDOW_HEIGHT: win_h  = cfg_wdata[3:0];
                    REG_STRIDE_WIDTH:  step_w = cfg_wdata[3:0];
                    REG_STRIDE_HEIGHT: step_h = cfg_wdata[3:0];
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

[tb/tb_top.sv]
// Testbench top for the 2-D max pooling block: clock, reset, stimulus and verdict.
`default_nettype none
module tb_top;
    import mp2d_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    int          fail_count, pending, result_count;
    int          pixels_sent = 0;
    int          stall_left = 0;
    bit          stall_done = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    max_pool_2d_forward uut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_index, .cfg_wdata
    );

    pool_checker chk (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_index, .cfg_wdata,
        .fail_count, .pending, .result_count
    );

    // Idle percentages by phase: sender-light first, then swapped, then none.
    function automatic int sender_idle_pct();
        if (pixels_sent < 150) return 28;
        if (pixels_sent < 300) return 87;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (pixels_sent < 150) return 87;
        if (pixels_sent < 300) return 28;
        return 0;
    endfunction

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (!stall_done && pixels_sent >= 200) begin
                stall_left = 400;
                stall_done = 1'b1;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct());
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_pixel(input logic [31:0] px);
        while ($urandom_range(0, 99) < sender_idle_pct()) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pixels_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (80) @(negedge aclk);
    endtask

    task automatic configure(input int iw, input int ih, input int ow, input int oh,
                             input int ww, input int wh, input int sw, input int sh);
        int vals [8];
        vals = '{iw, ih, ow, oh, ww, wh, sw, sh};
        for (int i = 0; i < 8; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_wdata <= 16'(vals[i]);
            @(negedge aclk);
        end
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_pixel();
        logic [31:0] specials [10];
        specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                     32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
                     32'h0000_0001, 32'h8000_0001};
        case ($urandom_range(0, 9))
            0, 1:    return specials[$urandom_range(0, 9)];
            2, 3:    return {1'($urandom_range(0, 1)), 8'd127, 23'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_window();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(9, 15);
            default: return $urandom_range(1, 4);
        endcase
    endfunction

    function automatic int pick_out_size(input int hi);
        case ($urandom_range(0, 7))
            0:       return 0;
            1, 2:    return $urandom_range(1, 3);
            default: return $urandom_range(8, hi);
        endcase
    endfunction

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [31:0] plane [16];
        int iw, ih, planes;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset setting: 1x1 planes with a 2x2 window, nothing comes out.
        for (int i = 0; i < 3; i++) send_pixel(pick_pixel());
        wait_idle();

        // 4x4 plane, 2x2 window, stride 2: all-NaN window, signed zeros, infinities.
        configure(4, 4, 2, 2, 2, 2, 2, 2);
        plane = '{32'h7FC0_0000, 32'hFFC0_0001, 32'h0000_0000, 32'h8000_0000,
                  32'h7F80_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                  32'hFF80_0000, 32'h7F80_0000, 32'h0000_0001, 32'h8000_0001,
                  32'hFF7F_FFFF, 32'h7F7F_FFFF, 32'h3F80_0000, 32'hBF80_0000};
        foreach (plane[i]) send_pixel(plane[i]);
        wait_idle();

        // Oversized width, widest window, zero stride.
        configure(511, 1, 511, 65535, 15, 1, 0, 15);
        for (int i = 0; i < 256; i++) send_pixel(pick_pixel());
        wait_idle();

        // Full 8x8 window over an 8x8 plane.
        configure(8, 8, 1, 1, 8, 8, 8, 8);
        for (int i = 0; i < 64; i++) send_pixel(pick_pixel());
        wait_idle();

        // Zero registers act as one.
        configure(0, 0, 3, 3, 0, 0, 0, 0);
        for (int i = 0; i < 4; i++) send_pixel(pick_pixel());
        wait_idle();

        while (pixels_sent < 450) begin
            iw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
            ih = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
            configure(iw, ih, pick_out_size(511), pick_out_size(300),
                      pick_window(), pick_window(),
                      $urandom_range(0, 3), $urandom_range(0, 3));
            planes = $urandom_range(1, 3);
            repeat (planes * (iw == 0 ? 1 : iw) * (ih == 0 ? 1 : ih))
                send_pixel(pick_pixel());
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire
